// File: rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; used by the cell, the top level and the checker.
package pls_pkg;

  // Fixed port widths.
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int PORT_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Highest position the position port can express.
  localparam int POS_MAX = 15;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Operation broadcast to every cell of the chain.
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_DELETE = 2'd2;
  localparam logic [1:0] CELL_WRITE  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [PORT_W-1:0] value;
  } pls_cmd_t;

endpackage

// File: rtl/pls_cell.sv
// One storage cell of the positional list chain.
// Depends on pls_pkg for the broadcast command type and operation codes.
module pls_cell #(
  parameter int ENTRY_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  pls_pkg::pls_cmd_t      cmd,
  input  logic [ENTRY_WIDTH-1:0] lower,
  input  logic [ENTRY_WIDTH-1:0] upper,
  output logic [ENTRY_WIDTH-1:0] slot
);

  logic                   at_pos;
  logic                   above_pos;
  logic [ENTRY_WIDTH-1:0] slot_next;

  // Place of this cell relative to the addressed position.
  assign at_pos    = (INDEX <= pls_pkg::POS_MAX) &&
                     (cmd.pos == pls_pkg::POS_W'(INDEX));
  assign above_pos = (INDEX > pls_pkg::POS_MAX) ||
                     (pls_pkg::POS_W'(INDEX) > cmd.pos);

  // Insert moves cells above the position up and loads the new value at it;
  // delete pulls cells at and above the position down from the upper neighbor; write loads the value at it.
  always_comb begin
    slot_next = slot;
    case (cmd.op)
      pls_pkg::CELL_INSERT: begin
        if (above_pos) begin
          slot_next = lower;
        end else if (at_pos) begin
          slot_next = ENTRY_WIDTH'(cmd.value);
        end
      end
      pls_pkg::CELL_DELETE: begin
        if (above_pos || at_pos) begin
          slot_next = upper;
        end
      end
      pls_pkg::CELL_WRITE: begin
        if (at_pos) begin
          slot_next = ENTRY_WIDTH'(cmd.value);
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// File: rtl/positional_list_store_core.sv
// Positional list store: an ordered list held in a chain of cells.
// Throughput: one transaction per cycle while the sink does not stall a held
// result; the result is registered and shows in the cycle after acceptance.
// Every cell decides its shift from the broadcast position in parallel.
// Reset clears the occupancy and the output valid; entry contents stay
// undefined until written.
module positional_list_store_core #(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pls_pkg::FUNC_W-1:0]    func,
  input  logic [pls_pkg::POS_W-1:0]     position,
  input  logic [pls_pkg::PORT_W-1:0]    entry_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pls_pkg::PORT_W-1:0]    entry_out,
  output logic [pls_pkg::STATUS_W-1:0]  status,
  output logic [pls_pkg::COUNT_W-1:0]   count
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (OCC_W > pls_pkg::POS_W) ? OCC_W : pls_pkg::POS_W;

  logic                            accept;
  logic [OCC_W-1:0]                occupancy;
  logic [OCC_W-1:0]                occupancy_next;
  logic [CMP_W-1:0]                occ_ext;
  logic [CMP_W-1:0]                pos_ext;
  logic [IDX_W-1:0]                pos_idx;
  logic                            full;
  logic [1:0]                      cell_op;
  logic [pls_pkg::STATUS_W-1:0]    status_next;
  logic [ENTRY_WIDTH-1:0]          result_next;
  pls_pkg::pls_cmd_t               cmd;
  logic [ENTRY_WIDTH-1:0]          slots [DEPTH];

  // A new transaction is taken unless a finished result is held up.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign occ_ext = CMP_W'(occupancy);
  assign pos_ext = CMP_W'(position);
  assign pos_idx = IDX_W'(position);
  assign full    = (occupancy == OCC_W'(DEPTH));

  // Decode the request, check bounds and pick the chain operation.
  always_comb begin
    cell_op        = pls_pkg::CELL_HOLD;
    status_next    = pls_pkg::ST_DONE;
    result_next    = '0;
    occupancy_next = occupancy;
    case (func)
      pls_pkg::FUNC_INSERT: begin
        if (full) begin
          status_next = pls_pkg::ST_FULL;
        end else if (pos_ext > occ_ext) begin
          status_next = pls_pkg::ST_RANGE;
        end else begin
          cell_op        = pls_pkg::CELL_INSERT;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end
      pls_pkg::FUNC_DELETE: begin
        if (pos_ext >= occ_ext) begin
          status_next = pls_pkg::ST_RANGE;
        end else begin
          cell_op        = pls_pkg::CELL_DELETE;
          result_next    = slots[pos_idx];
          occupancy_next = occupancy - OCC_W'(1);
        end
      end
      pls_pkg::FUNC_REPLACE: begin
        if (pos_ext >= occ_ext) begin
          status_next = pls_pkg::ST_RANGE;
        end else begin
          cell_op = pls_pkg::CELL_WRITE;
        end
      end
      pls_pkg::FUNC_RETRIEVE: begin
        if (pos_ext >= occ_ext) begin
          status_next = pls_pkg::ST_RANGE;
        end else begin
          result_next = slots[pos_idx];
        end
      end
      pls_pkg::FUNC_CLEAR: begin
        occupancy_next = '0;
      end
      default: begin
        cell_op = pls_pkg::CELL_HOLD;
      end
    endcase
  end

  // The chain only moves on an accepted transaction.
  assign cmd.op    = accept ? cell_op : pls_pkg::CELL_HOLD;
  assign cmd.pos   = position;
  assign cmd.value = entry_in;

  // Row of cells, each linked to its lower and upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] lower;
    logic [ENTRY_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_inner_lo
      assign lower = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner_hi
      assign upper = slots[i+1];
    end

    pls_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .lower (lower),
      .upper (upper),
      .slot  (slots[i])
    );
  end

  // Occupancy and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        occupancy <= occupancy_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_out <= pls_pkg::PORT_W'(result_next);
      status    <= status_next;
      count     <= pls_pkg::COUNT_W'(occupancy_next);
    end
  end

endmodule

// File: rtl/pls_checker.sv
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg for the status codes and port widths.
module pls_checker #(
  parameter int DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pls_pkg::PORT_W-1:0]    entry_out,
  input logic [pls_pkg::STATUS_W-1:0]  status,
  input logic [pls_pkg::COUNT_W-1:0]   count
);

  // A held result does not change while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_out) &&
                               $stable(status) && $stable(count))
    else $error("stalled result changed");

  // Only the three defined status codes are ever reported.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == pls_pkg::ST_DONE) || (status == pls_pkg::ST_FULL) ||
                  (status == pls_pkg::ST_RANGE))
    else $error("undefined status code");

  // A full refusal reports a store holding all entries.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pls_pkg::ST_FULL) |->
      count == pls_pkg::COUNT_W'(DEPTH))
    else $error("full status with store not full");

  // A refused transaction returns no entry.
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != pls_pkg::ST_DONE) |-> entry_out == '0)
    else $error("refused transaction returned data");

  // The count never exceeds the store depth when the port can show it.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 31) || (count <= pls_pkg::COUNT_W'(DEPTH)))
    else $error("count above depth");

endmodule

bind positional_list_store_core pls_checker #(
  .DEPTH (DEPTH)
) u_pls_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .entry_out (entry_out),
  .status    (status),
  .count     (count)
);

// File: sim/tb_top.sv
// Self-checking testbench for positional_list_store_core: directed and random
// list requests, with a scoreboard class that predicts every result.
// Depends on rtl/pls_pkg.sv and rtl/positional_list_store_core.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int ENTRY_WIDTH  = 32;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // Function codes that the block ignores.
  localparam logic [pls_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [pls_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct {
    logic [pls_pkg::PORT_W-1:0]   entry;
    logic [pls_pkg::STATUS_W-1:0] status;
    logic [pls_pkg::COUNT_W-1:0]  count;
  } list_result_t;

  // Scoreboard: keeps its own copy of the list and the results still owed.
  class list_scoreboard;
    logic [ENTRY_WIDTH-1:0] slots[DEPTH];
    int                     occupancy;
    list_result_t           owed[$];
    int                     mismatches;

    function new();
      occupancy  = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the list copy and queue its result.
    function void note_request(logic [pls_pkg::FUNC_W-1:0] f,
                               logic [pls_pkg::POS_W-1:0] p,
                               logic [pls_pkg::PORT_W-1:0] v);
      list_result_t res;
      int           pos;
      pos        = int'(p);
      res.entry  = '0;
      res.status = pls_pkg::ST_DONE;
      case (f)
        pls_pkg::FUNC_INSERT: begin
          if (occupancy >= DEPTH) begin
            res.status = pls_pkg::ST_FULL;
          end else if (pos > occupancy) begin
            res.status = pls_pkg::ST_RANGE;
          end else begin
            for (int i = occupancy; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = v[ENTRY_WIDTH-1:0];
            occupancy++;
          end
        end
        pls_pkg::FUNC_DELETE: begin
          if (pos >= occupancy) begin
            res.status = pls_pkg::ST_RANGE;
          end else begin
            res.entry = pls_pkg::PORT_W'(slots[pos]);
            for (int i = pos; i + 1 < occupancy; i++) slots[i] = slots[i+1];
            occupancy--;
          end
        end
        pls_pkg::FUNC_REPLACE: begin
          if (pos >= occupancy) res.status = pls_pkg::ST_RANGE;
          else slots[pos] = v[ENTRY_WIDTH-1:0];
        end
        pls_pkg::FUNC_RETRIEVE: begin
          if (pos >= occupancy) res.status = pls_pkg::ST_RANGE;
          else res.entry = pls_pkg::PORT_W'(slots[pos]);
        end
        pls_pkg::FUNC_CLEAR: begin
          occupancy = 0;
        end
        default: begin
        end
      endcase
      res.count = pls_pkg::COUNT_W'(occupancy);
      owed.push_back(res);
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_result(logic [pls_pkg::PORT_W-1:0] e,
                               logic [pls_pkg::STATUS_W-1:0] s,
                               logic [pls_pkg::COUNT_W-1:0] c);
      list_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: entry=%h status=%0d count=%0d", e, s, c);
        return;
      end
      want = owed.pop_front();
      if (e !== want.entry || s !== want.status || c !== want.count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"mismatch: expected entry=%h status=%0d count=%0d,",
                    " got entry=%h status=%0d count=%0d"},
                   want.entry, want.status, want.count, e, s, c);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [pls_pkg::FUNC_W-1:0]   func;
  logic [pls_pkg::POS_W-1:0]    position;
  logic [pls_pkg::PORT_W-1:0]   entry_in;
  logic                         out_valid;
  logic                         out_stall;
  logic [pls_pkg::PORT_W-1:0]   entry_out;
  logic [pls_pkg::STATUS_W-1:0] status;
  logic [pls_pkg::COUNT_W-1:0]  count;

  list_scoreboard sb;
  int             cycles;
  int             burst_left;

  positional_list_store_core #(
    .DEPTH      (DEPTH),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .position (position),
    .entry_in (entry_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .entry_out(entry_out),
    .status   (status),
    .count    (count)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result monitor: every accepted output transaction is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(entry_out, status, count);
  end

  // Receiver stall pattern: free, random, periodic and long-stall stretches.
  int stall_mode;
  int mode_left;
  int period_ctr;
  int stall_run;
  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
        stall_run  = 0;
      end
      mode_left--;
      period_ctr++;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 99) < 30);
        2: out_stall = (period_ctr % 3 == 0);
        default: begin
          if (stall_run == 0) stall_run = $urandom_range(1, 12);
          stall_run--;
          out_stall = (stall_run > 3);
        end
      endcase
    end
  end

  // Present one request and hold it until the block accepts the transaction.
  task automatic send_request(logic [pls_pkg::FUNC_W-1:0] f,
                              logic [pls_pkg::POS_W-1:0] p,
                              logic [pls_pkg::PORT_W-1:0] v);
    int gap;
    @(negedge clk);
    func     = f;
    position = p;
    entry_in = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, p, v);
    // Bursts of back-to-back transactions separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 15);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      func     = pls_pkg::FUNC_W'($urandom);
      position = pls_pkg::POS_W'($urandom);
      entry_in = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Draw a random request, mostly well formed against the current list.
  task automatic random_request(bit filling);
    int                         r;
    int                         occ;
    logic [pls_pkg::FUNC_W-1:0] f;
    logic [pls_pkg::POS_W-1:0]  p;
    occ = sb.occupancy;
    r   = $urandom_range(0, 99);
    if (filling) begin
      if      (r < 50) f = pls_pkg::FUNC_INSERT;
      else if (r < 65) f = pls_pkg::FUNC_DELETE;
      else if (r < 77) f = pls_pkg::FUNC_REPLACE;
      else if (r < 94) f = pls_pkg::FUNC_RETRIEVE;
      else if (r < 96) f = pls_pkg::FUNC_CLEAR;
      else f = pls_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    end else begin
      if      (r < 15) f = pls_pkg::FUNC_INSERT;
      else if (r < 65) f = pls_pkg::FUNC_DELETE;
      else if (r < 77) f = pls_pkg::FUNC_REPLACE;
      else if (r < 94) f = pls_pkg::FUNC_RETRIEVE;
      else if (r < 96) f = pls_pkg::FUNC_CLEAR;
      else f = pls_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    end
    // Mostly in-range positions, the rest anywhere the port allows.
    if ($urandom_range(0, 99) < 85) begin
      if (f == pls_pkg::FUNC_INSERT)
        p = (occ > pls_pkg::POS_MAX) ? pls_pkg::POS_W'($urandom_range(0, pls_pkg::POS_MAX))
                                     : pls_pkg::POS_W'($urandom_range(0, occ));
      else if (occ > 0) p = pls_pkg::POS_W'($urandom_range(0, occ - 1));
      else              p = pls_pkg::POS_W'($urandom_range(0, pls_pkg::POS_MAX));
    end else begin
      p = pls_pkg::POS_W'($urandom_range(0, pls_pkg::POS_MAX));
    end
    send_request(f, p, $urandom);
  endtask

  initial begin
    sb         = new();
    cycles     = 0;
    burst_left = 0;
    stall_mode = 0;
    mode_left  = 0;
    period_ctr = 0;
    stall_run  = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    func       = pls_pkg::FUNC_INSERT;
    position   = '0;
    entry_in   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Requests on an empty list, then the insert edge cases.
    send_request(pls_pkg::FUNC_RETRIEVE, 4'd0, 32'h0);
    send_request(pls_pkg::FUNC_DELETE, 4'd0, 32'h0);
    send_request(pls_pkg::FUNC_REPLACE, 4'd0, 32'h1234_5678);
    send_request(pls_pkg::FUNC_INSERT, 4'd3, 32'hDEAD_BEEF);
    send_request(pls_pkg::FUNC_INSERT, 4'd0, 32'h0000_0000);
    send_request(pls_pkg::FUNC_INSERT, 4'd1, 32'hFFFF_FFFF);
    send_request(pls_pkg::FUNC_INSERT, 4'd1, 32'hA5A5_5A5A);
    // Fill the list up to its capacity by inserts at the front.
    while (sb.occupancy < DEPTH) send_request(pls_pkg::FUNC_INSERT, 4'd0, $urandom);
    // A full list refuses inserts before the position is looked at.
    send_request(pls_pkg::FUNC_INSERT, 4'd15, 32'h1111_1111);
    send_request(pls_pkg::FUNC_INSERT, 4'd0, 32'h2222_2222);
    send_request(pls_pkg::FUNC_RETRIEVE, 4'd15, 32'h0);
    send_request(pls_pkg::FUNC_REPLACE, 4'd15, 32'hFFFF_FFFF);
    send_request(pls_pkg::FUNC_DELETE, 4'd15, 32'h0);
    send_request(pls_pkg::FUNC_INSERT, 4'd15, 32'h8000_0001);
    send_request(pls_pkg::FUNC_DELETE, 4'd0, 32'h0);
    send_request(pls_pkg::FUNC_RETRIEVE, 4'd0, 32'h0);
    send_request(pls_pkg::FUNC_CLEAR, 4'd9, 32'hFFFF_FFFF);
    send_request(FUNC_UNUSED_HI, 4'd15, 32'hFFFF_FFFF);

    // Random traffic that alternates between filling and draining the list.
    for (int i = 0; i < RANDOM_ITEMS; i++) random_request(((i / 60) % 2) == 0);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/positional_list_store_core.sv
rtl/pls_checker.sv
sim/tb_top.sv
